### sv/rtt_rto_estimator_unit_defines.svh
// ---------------------------------------------------------------------------
// RTT/RTO estimator assertion macros
// Shared concurrent assertion forms for the estimator RTL.
// ---------------------------------------------------------------------------
`ifndef RTT_RTO_ESTIMATOR_UNIT_DEFINES_SVH
`define RTT_RTO_ESTIMATOR_UNIT_DEFINES_SVH

// Check that a condition implies another one in the next cycle
`define RRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rre assertion failed: next-cycle implication");

// Check that a condition implies another one in the same cycle
`define RRE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rre assertion failed: same-cycle implication");

`endif

### sv/rre_pkg.sv
// ---------------------------------------------------------------------------
// RTT/RTO estimator package
// Sequencer states, opcodes, register indexes and field widths.
// ---------------------------------------------------------------------------
package rre_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WEIGHT_W = 9;
    localparam int unsigned PROD_W   = TIME_W + WEIGHT_W;
    localparam int unsigned CFG_IDX_W = 3;

    // Opcodes
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_BACKOFF = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RTT_ALPHA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RTO_BETA    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RTT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RTT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RTO = 3'd5;

    // Full Q1.8 weight
    localparam logic [WEIGHT_W-1:0] ALPHA_ONE = 9'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_OLD,
        S_MUL_NEW,
        S_SUM,
        S_MUL_TO,
        S_SCALE,
        S_DONE
    } t_state;

endpackage

### sv/rtt_rto_estimator_unit.sv
// ---------------------------------------------------------------------------
// RTT/RTO estimator unit
// Smoothed round-trip time and retransmission timeout for one connection.
// ---------------------------------------------------------------------------
// A valid rtt sample item keeps the sequencer busy while three products (old
// smoothed rtt by alpha, sample by 256 - alpha, new smoothed rtt by beta)
// pass one after another through the single registered 32 x 9 multiplier,
// with a sum after the second and a scaling step after the third. Backoff,
// load, invalid samples and the unused opcode go straight to the final step.
// s_axis_tready is high only while the sequencer is idle; a finished result
// sits in the output register, and the next item is accepted while it waits.
// The sequencer holds its final step until the output register is free.
module rtt_rto_estimator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [rre_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // send_time[31:0], ack_time[63:32]
    input  logic [2:0]  s_axis_tuser,   // opcode[1:0], sample_valid[2]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // smoothed_rtt_out[31:0], timeout_out[63:32]
    output logic [0:0]  m_axis_tuser    // changed[0]
);
    import rre_pkg::*;

    `include "rtt_rto_estimator_unit_defines.svh"

    // Configuration registers
    logic [8:0]        r_alpha;
    logic [7:0]        r_beta;
    logic [TIME_W-1:0] r_max_to;
    logic [9:0]        r_min_rtt;
    logic [TIME_W-1:0] r_init_rtt;
    logic [TIME_W-1:0] r_init_rto;

    // Estimator state
    logic [TIME_W-1:0] r_srtt;
    logic [TIME_W-1:0] r_rto;

    // Per-item work registers
    t_state              r_state, n_state;
    logic [TIME_W-1:0]   r_rtt;
    logic [WEIGHT_W-1:0] r_a;
    logic [TIME_W:0]     r_acc;
    logic [TIME_W-1:0]   r_new_rtt;
    logic [TIME_W-1:0]   r_new_rto;

    // Output register
    logic              r_out_valid;
    logic [TIME_W-1:0] r_out_rtt;
    logic [TIME_W-1:0] r_out_rto;
    logic              r_out_changed;

    // Shared multiplier
    logic [TIME_W-1:0]   mul_a;
    logic [WEIGHT_W-1:0] mul_b;
    logic [PROD_W-1:0]   mul_p;

    logic s_fire, m_fire, out_free, out_load;
    logic [1:0]        in_op;
    logic              in_valid;
    logic [TIME_W-1:0] in_send, in_ack, diff, rtt_clamped;
    logic [TIME_W:0]   dbl;
    logic [TIME_W-1:0] backoff_rto;
    logic [TIME_W+1:0] sum;
    logic [PROD_W-5:0] scaled;

    rre_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign in_op    = s_axis_tuser[1:0];
    assign in_valid = s_axis_tuser[2];
    assign in_send  = s_axis_tdata[31:0];
    assign in_ack   = s_axis_tdata[63:32];

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign m_fire   = r_out_valid && m_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (r_state == S_DONE) && out_free;

    // Clamp the sample up to the minimum rtt; a negative difference also gets the minimum
    always_comb begin
        diff = in_ack - in_send;
        if (diff[TIME_W-1] || (diff < TIME_W'(r_min_rtt))) begin
            rtt_clamped = TIME_W'(r_min_rtt);
        end else begin
            rtt_clamped = diff;
        end
    end

    // Double the timeout, capped at the maximum
    always_comb begin
        dbl = {r_rto, 1'b0};
        if (dbl < {1'b0, r_max_to}) begin
            backoff_rto = dbl[TIME_W-1:0];
        end else begin
            backoff_rto = r_max_to;
        end
    end

    assign sum    = {1'b0, r_acc} + {1'b0, mul_p[PROD_W-1:8]};
    assign scaled = mul_p[PROD_W-1:4];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    if ((in_op == OP_SAMPLE) && in_valid) begin
                        n_state = S_MUL_OLD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MUL_OLD: n_state = S_MUL_NEW;
            S_MUL_NEW: n_state = S_SUM;
            S_SUM:     n_state = S_MUL_TO;
            S_MUL_TO:  n_state = S_SCALE;
            S_SCALE:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: ready and multiplier operands
    always_comb begin
        s_axis_tready = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_MUL_OLD: begin
                mul_a = r_srtt;
                mul_b = r_a;
            end
            S_MUL_NEW: begin
                mul_a = r_rtt;
                mul_b = ALPHA_ONE - r_a;
            end
            S_MUL_TO: begin
                mul_a = r_new_rtt;
                mul_b = {1'b0, r_beta};
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_srtt      <= '0;
            r_rto       <= '0;
            r_alpha     <= 9'd224;
            r_beta      <= 8'd32;
            r_max_to    <= 32'd60000;
            r_min_rtt   <= 10'd10;
            r_init_rtt  <= 32'd0;
            r_init_rto  <= 32'd3000;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_srtt      <= r_new_rtt;
                r_rto       <= r_new_rto;
            end else if (m_fire) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RTT_ALPHA:   r_alpha    <= i_cfg_wdata[8:0];
                    REG_RTO_BETA:    r_beta     <= i_cfg_wdata[7:0];
                    REG_MAX_TIMEOUT: r_max_to   <= i_cfg_wdata;
                    REG_MIN_RTT:     r_min_rtt  <= i_cfg_wdata[9:0];
                    REG_INITIAL_RTT: r_init_rtt <= i_cfg_wdata;
                    REG_INITIAL_RTO: r_init_rto <= i_cfg_wdata;
                    default: begin
                        r_alpha <= r_alpha;
                    end
                endcase
            end
        end
    end

    // Work and payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    r_rtt <= rtt_clamped;
                    r_a   <= r_alpha[8] ? ALPHA_ONE : r_alpha;
                    case (in_op)
                        OP_BACKOFF: begin
                            r_new_rtt <= r_srtt;
                            r_new_rto <= backoff_rto;
                        end
                        OP_LOAD: begin
                            r_new_rtt <= r_init_rtt;
                            r_new_rto <= r_init_rto;
                        end
                        default: begin
                            r_new_rtt <= r_srtt;
                            r_new_rto <= r_rto;
                        end
                    endcase
                end
            end
            // Hold the scaled old term
            S_MUL_NEW: r_acc <= mul_p[PROD_W-1:8];
            // Add the sample term, saturate
            S_SUM: begin
                r_new_rtt <= (sum[TIME_W+1:TIME_W] != 2'b00) ? '1 : sum[TIME_W-1:0];
            end
            // Scale the timeout, saturate
            S_SCALE: begin
                r_new_rto <= (scaled[PROD_W-5:TIME_W] != '0) ? '1 : scaled[TIME_W-1:0];
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_rtt     <= r_new_rtt;
                    r_out_rto     <= r_new_rto;
                    r_out_changed <= (r_new_rtt != r_srtt) || (r_new_rto != r_rto);
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out_rto, r_out_rtt};
    assign m_axis_tuser[0] = r_out_changed;

    // Assertions
    `RRE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_fire, !s_axis_tready)
    `RRE_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !out_load, $stable(r_srtt) && $stable(r_rto))
    `RRE_ASSERT_NEXT(a_changed_flag, i_clk, i_rst_n, out_load,
        r_out_changed == ((r_srtt != $past(r_srtt)) || (r_rto != $past(r_rto))))
    `RRE_ASSERT_SAME(a_load_needs_room, i_clk, i_rst_n, out_load, !r_out_valid || m_axis_tready)

endmodule

### sv/rre_mul.sv
// ---------------------------------------------------------------------------
// RTT/RTO estimator shared multiplier
// One 32 x 9 unsigned multiply with a registered product.
// ---------------------------------------------------------------------------
module rre_mul (
    input  logic                        i_clk,
    input  logic [rre_pkg::TIME_W-1:0]   i_a,
    input  logic [rre_pkg::WEIGHT_W-1:0] i_b,
    output logic [rre_pkg::PROD_W-1:0]   o_p
);
    import rre_pkg::*;

    logic [PROD_W-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule
